/* hw/rtl/gpe_pkg.sv */
// Shared types, constants and helpers for the GPIO port with edge interrupts.
`timescale 1ns / 1ps
`default_nettype none
package gpe_pkg;

   localparam int PIN_COUNT = 8;
   localparam int PIN_W     = 3;
   localparam int CSR_IDX_W = 2;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OUTPUT_DIRECTION = 2'd0,
      CSR_IRQ_ENABLE_MASK  = 2'd1,
      CSR_RISE_MASK        = 2'd2,
      CSR_FALL_MASK        = 2'd3
   } csr_index_type;

   // Command codes; codes 6 and 7 are unused and change nothing.
   typedef enum logic [2:0] {
      CMD_SAMPLE     = 3'd0,
      CMD_WRITE_BIT  = 3'd1,
      CMD_READ_BIT   = 3'd2,
      CMD_READ_STAT  = 3'd3,
      CMD_CLEAR_PIN  = 3'd4,
      CMD_CLEAR_ALL  = 3'd5
   } cmd_type;

   typedef struct packed {
      logic [PIN_COUNT-1:0] output_direction;
      logic [PIN_COUNT-1:0] irq_enable_mask;
      logic [PIN_COUNT-1:0] rise_mask;
      logic [PIN_COUNT-1:0] fall_mask;
   } cfg_type;

   // Result fields, most significant first, so the packed form is the tdata layout.
   typedef struct packed {
      logic [RSP_DATA_W-27:0] pad;
      logic                   irq;
      logic [PIN_COUNT-1:0]   pad_output_enable;
      logic [PIN_COUNT-1:0]   pad_drive;
      logic [PIN_COUNT-1:0]   pending;
      logic                   read_bit;
   } rsp_type;

   // One-hot mask of a pin; pins beyond the port select nothing.
   function automatic logic [PIN_COUNT-1:0] pin_bit(input logic [PIN_W-1:0] pin);
      logic [PIN_COUNT-1:0] mask;
      mask = '0;
      if (int'(pin) < PIN_COUNT) begin
         mask = PIN_COUNT'(1) << pin;
      end
      return mask;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/gpe_csr.sv */
// Configuration registers of the GPIO port: direction, interrupt enable, edge masks.
`timescale 1ns / 1ps
`default_nettype none
module gpe_csr
   import gpe_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [PIN_COUNT-1:0] csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_OUTPUT_DIRECTION: cfg_in.output_direction = csr_wdata;
            CSR_IRQ_ENABLE_MASK:  cfg_in.irq_enable_mask  = csr_wdata;
            CSR_RISE_MASK:        cfg_in.rise_mask        = csr_wdata;
            CSR_FALL_MASK:        cfg_in.fall_mask        = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

/* hw/rtl/gpe_core.sv */
// Port state (output latch, sampled levels, sticky status) and per-command result logic.
`timescale 1ns / 1ps
`default_nettype none
module gpe_core
   import gpe_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  cfg_type                   cfg,
   input  wire logic                 accept,
   input  wire logic [2:0]           cmd,
   input  wire logic [PIN_W-1:0]     pin,
   input  wire logic                 value,
   input  wire logic [PIN_COUNT-1:0] pad_levels,
   output rsp_type                   result
);

   logic [PIN_COUNT-1:0] latch_ff, latch_in;
   logic [PIN_COUNT-1:0] sampled_ff, sampled_in;
   logic [PIN_COUNT-1:0] status_ff, status_in;
   logic [PIN_COUNT-1:0] sel;
   logic [PIN_COUNT-1:0] rising;
   logic [PIN_COUNT-1:0] falling;
   logic                 rd;

   assign sel     = pin_bit(pin);
   assign rising  = pad_levels & ~sampled_ff & cfg.rise_mask;
   assign falling = ~pad_levels & sampled_ff & cfg.fall_mask;

   always_comb begin
      latch_in   = latch_ff;
      sampled_in = sampled_ff;
      status_in  = status_ff;
      rd         = 1'b0;
      unique case (cmd_type'(cmd))
         CMD_SAMPLE: begin
            status_in  = status_ff | rising | falling;
            sampled_in = pad_levels;
         end
         CMD_WRITE_BIT: begin
            latch_in = value ? (latch_ff | sel) : (latch_ff & ~sel);
         end
         CMD_READ_BIT:  rd = |(sampled_ff & sel);
         CMD_READ_STAT: rd = 1'b0;
         CMD_CLEAR_PIN: status_in = status_ff & ~sel;
         CMD_CLEAR_ALL: status_in = '0;
         default:       rd = 1'b0;
      endcase
   end

   // The result reports the state as it stands after this transaction.
   always_comb begin
      result                   = '0;
      result.read_bit          = rd;
      result.pending           = status_in;
      result.pad_drive         = latch_in;
      result.pad_output_enable = cfg.output_direction;
      result.irq               = |(status_in & cfg.irq_enable_mask);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff   <= '0;
         sampled_ff <= '0;
         status_ff  <= '0;
      end else if (accept) begin
         latch_ff   <= latch_in;
         sampled_ff <= sampled_in;
         status_ff  <= status_in;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/gpe_skid.sv */
// Two-entry result buffer: an output register backed by a skid register.
`timescale 1ns / 1ps
`default_nettype none
module gpe_skid
   import gpe_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic      in_ready,
   input  rsp_type   in_data,
   output logic      out_valid,
   input  wire logic out_ready,
   output rsp_type   out_data
);

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_data_ff, out_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    take;

   assign in_ready = !skid_valid_ff;
   assign take     = out_valid_ff && out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // No new transaction can arrive while the skid register is full.
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_valid_ff || take) begin
            out_data_in  = in_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule
`default_nettype wire

/* hw/rtl/gpio_port_with_edge_interrupts.sv */
// Eight-pin GPIO port with sticky edge-interrupt status, streaming command interface.
//
// Each request transaction carries one command (sample pads, write an output bit, read a
// sampled bit, read status, clear one pin's status, clear all status) and produces exactly
// one response transaction that reports the read bit, the pending status, the output latch,
// the output enables and the interrupt line as they stand after the command. One request is
// accepted every clock cycle unless the request side stalls; each response is registered. A
// two-entry output buffer lets requests keep flowing while a response waits, so the request
// side stalls only once two responses are held. Configuration writes take effect in the
// cycle after the write enable and must be made while no transaction is in flight.
`timescale 1ns / 1ps
`default_nettype none
module gpio_port_with_edge_interrupts
   import gpe_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [PIN_COUNT-1:0]  csr_wdata,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // Fields from bit 0: cmd[2:0], pin[5:3], value[6], pad_levels[14:7], zero[15].
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // Fields from bit 0: read_bit[0], pending[8:1], pad_drive[16:9],
   // pad_output_enable[24:17], irq[25], zero[31:26].
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   cfg_type cfg;
   rsp_type result;
   rsp_type rsp_data;
   logic    accept;

   assign accept = req_tvalid && req_tready;

   gpe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gpe_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .accept     (accept),
      .cmd        (req_tdata[2:0]),
      .pin        (req_tdata[5:3]),
      .value      (req_tdata[6]),
      .pad_levels (req_tdata[14:7]),
      .result     (result)
   );

   gpe_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_ready  (req_tready),
      .in_data   (result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   assign rsp_tdata = RSP_DATA_W'(rsp_data);

endmodule
`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the GPIO port with edge interrupts.
`timescale 1ns / 1ps
module tb_top;
   import gpe_pkg::*;

   localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
   localparam logic [2:0] CMD_UNUSED_7 = 3'd7;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 106;
   localparam int HOLD_START     = 300;
   localparam int HOLD_CYCLES    = 80;
   localparam int STEADY_FIRST   = 450;
   localparam int STEADY_LAST    = 600;
   localparam int CYCLE_LIMIT    = 200000;
   localparam rsp_type OE_ONLY_REPORT = '{pad: '0, irq: 1'b0, pad_output_enable: 8'hFF,
                                          pad_drive: 8'h00, pending: 8'h00, read_bit: 1'b0};

   typedef struct {
      logic          is_csr;
      csr_index_type idx;
      logic [7:0]    wdata;
      logic [2:0]    cmd;
      logic [2:0]    pin;
      logic          value;
      logic [7:0]    pads;
      logic          known;
      rsp_type       want;
   } plan_row;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [PIN_COUNT-1:0]  csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Predictor copy of the port registers and state.
   logic [7:0] cfg_dir = '0, cfg_irq_en = '0, cfg_rise = '0, cfg_fall = '0;
   logic [7:0] port_latch = '0, port_levels = '0, port_status = '0;

   rsp_type port_reports[$];
   plan_row directed_rows[$];
   int      items_sent = 0;
   int      responses_checked = 0;
   int      mismatch_count = 0;
   int      settings_count = 1;
   int      cycle_count = 0;

   gpio_port_with_edge_interrupts uut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles.", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic rsp_type advance_port(input logic [2:0] cmd, input logic [2:0] pin,
                                            input logic value, input logic [7:0] pads);
      rsp_type    r;
      logic [7:0] sel;
      r = '0;
      sel = 8'd1 << pin;
      case (cmd)
         CMD_SAMPLE: begin
            port_status |= (pads & ~port_levels & cfg_rise) | (~pads & port_levels & cfg_fall);
            port_levels = pads;
         end
         CMD_WRITE_BIT: port_latch = value ? (port_latch | sel) : (port_latch & ~sel);
         CMD_READ_BIT:  r.read_bit = |(port_levels & sel);
         CMD_CLEAR_PIN: port_status &= ~sel;
         CMD_CLEAR_ALL: port_status = '0;
         default: ;
      endcase
      r.pending           = port_status;
      r.pad_drive         = port_latch;
      r.pad_output_enable = cfg_dir;
      r.irq               = |(port_status & cfg_irq_en);
      return r;
   endfunction

   function automatic plan_row item_row(input logic [2:0] cmd, input logic [2:0] pin,
                                        input logic value, input logic [7:0] pads);
      plan_row r;
      r = '{is_csr: 1'b0, idx: CSR_OUTPUT_DIRECTION, wdata: '0, cmd: cmd, pin: pin,
            value: value, pads: pads, known: 1'b0, want: '0};
      return r;
   endfunction

   function automatic plan_row known_row(input logic [2:0] cmd, input logic [2:0] pin,
                                         input logic value, input logic [7:0] pads,
                                         input rsp_type want);
      plan_row r;
      r = item_row(cmd, pin, value, pads);
      r.known = 1'b1;
      r.want = want;
      return r;
   endfunction

   function automatic plan_row csr_row(input csr_index_type idx, input logic [7:0] data);
      plan_row r;
      r = item_row(CMD_READ_STAT, '0, 1'b0, '0);
      r.is_csr = 1'b1;
      r.idx = idx;
      r.wdata = data;
      return r;
   endfunction

   function automatic logic [2:0] pick_cmd();
      int r;
      r = $urandom_range(99);
      if (r < 35) return CMD_SAMPLE;
      if (r < 50) return CMD_WRITE_BIT;
      if (r < 65) return CMD_READ_BIT;
      if (r < 75) return CMD_READ_STAT;
      if (r < 87) return CMD_CLEAR_PIN;
      if (r < 95) return CMD_CLEAR_ALL;
      return $urandom_range(1) ? CMD_UNUSED_6 : CMD_UNUSED_7;
   endfunction

   function automatic logic [7:0] pick_mask();
      int r;
      r = $urandom_range(9);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return 8'($urandom);
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] seen);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("Mismatch on %s: expected %0h, got %0h", what, want, seen);
   endtask

   // Drops valid and lets the port drain every outstanding transaction.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (port_reports.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [7:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_OUTPUT_DIRECTION: cfg_dir = data;
         CSR_IRQ_ENABLE_MASK:  cfg_irq_en = data;
         CSR_RISE_MASK:        cfg_rise = data;
         CSR_FALL_MASK:        cfg_fall = data;
         default: ;
      endcase
   endtask

   task automatic send_command(input logic [2:0] cmd, input logic [2:0] pin, input logic value,
                               input logic [7:0] pads, input logic known, input rsp_type want);
      rsp_type model;
      // Gaps before a fifth of the transactions, outside the stretch without gaps, keep the
      // request side idle for part of the run.
      if (!(items_sent >= STEADY_FIRST && items_sent < STEADY_LAST) &&
          $urandom_range(99) < 20) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, pads, value, pin, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // The transaction was taken at this edge.
      model = advance_port(cmd, pin, value, pads);
      port_reports.push_back(known ? want : model);
      items_sent++;
   endtask

   initial begin : stimulus
      logic [7:0] pads;
      logic [2:0] cmd;
      directed_rows = '{
         known_row(CMD_READ_STAT, 3'd0, 1'b0, 8'h00, '0),
         known_row(CMD_UNUSED_6, 3'd7, 1'b1, 8'hFF, '0),
         known_row(CMD_UNUSED_7, 3'd0, 1'b0, 8'h00, '0),
         csr_row(CSR_OUTPUT_DIRECTION, 8'hFF),
         csr_row(CSR_IRQ_ENABLE_MASK, 8'hFF),
         csr_row(CSR_RISE_MASK, 8'hFF),
         csr_row(CSR_FALL_MASK, 8'hFF),
         known_row(CMD_READ_STAT, 3'd0, 1'b0, 8'h00, OE_ONLY_REPORT),
         // The first sample is compared against the all-low reset levels.
         item_row(CMD_SAMPLE, 3'd0, 1'b0, 8'hA5),
         item_row(CMD_SAMPLE, 3'd0, 1'b0, 8'h5A),
         item_row(CMD_READ_BIT, 3'd0, 1'b0, 8'h00),
         item_row(CMD_READ_BIT, 3'd1, 1'b0, 8'h00),
         item_row(CMD_READ_BIT, 3'd7, 1'b1, 8'hFF),
         item_row(CMD_WRITE_BIT, 3'd0, 1'b1, 8'h00),
         item_row(CMD_WRITE_BIT, 3'd7, 1'b1, 8'hFF),
         item_row(CMD_WRITE_BIT, 3'd7, 1'b0, 8'h00),
         item_row(CMD_CLEAR_PIN, 3'd3, 1'b0, 8'h00),
         item_row(CMD_CLEAR_PIN, 3'd0, 1'b1, 8'hFF),
         item_row(CMD_READ_STAT, 3'd5, 1'b1, 8'h0F),
         item_row(CMD_CLEAR_ALL, 3'd0, 1'b0, 8'h00),
         item_row(CMD_SAMPLE, 3'd0, 1'b0, 8'h00),
         item_row(CMD_SAMPLE, 3'd7, 1'b1, 8'hFF),
         item_row(CMD_UNUSED_6, 3'd2, 1'b1, 8'h3C),
         item_row(CMD_CLEAR_PIN, 3'd7, 1'b0, 8'h00),
         item_row(CMD_UNUSED_7, 3'd4, 1'b1, 8'hC3)
      };
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            wait_idle();
            write_reg(directed_rows[i].idx, directed_rows[i].wdata);
         end else begin
            send_command(directed_rows[i].cmd, directed_rows[i].pin, directed_rows[i].value,
                         directed_rows[i].pads, directed_rows[i].known, directed_rows[i].want);
         end
      end
      settings_count++;

      for (int p = 0; p < PHASES; p++) begin
         // Each phase pauses until every response is back, then loads a new setting.
         wait_idle();
         if (p == 0) begin
            write_reg(CSR_OUTPUT_DIRECTION, 8'h00);
            write_reg(CSR_IRQ_ENABLE_MASK, 8'h00);
            write_reg(CSR_RISE_MASK, 8'h00);
            write_reg(CSR_FALL_MASK, 8'h00);
         end else if (p == 1) begin
            write_reg(CSR_OUTPUT_DIRECTION, 8'hFF);
            write_reg(CSR_IRQ_ENABLE_MASK, 8'hFF);
            write_reg(CSR_RISE_MASK, 8'hFF);
            write_reg(CSR_FALL_MASK, 8'hFF);
         end else begin
            write_reg(CSR_OUTPUT_DIRECTION, pick_mask());
            write_reg(CSR_IRQ_ENABLE_MASK, pick_mask());
            write_reg(CSR_RISE_MASK, pick_mask());
            write_reg(CSR_FALL_MASK, pick_mask());
         end
         settings_count++;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            cmd = pick_cmd();
            // Single-pin toggles produce isolated edges; full random values produce many.
            if ($urandom_range(1)) pads = 8'($urandom);
            else pads = port_levels ^ (8'd1 << $urandom_range(7));
            send_command(cmd, 3'($urandom_range(7)), 1'($urandom_range(1)), pads, 1'b0, '0);
         end
      end

      wait_idle();
      repeat (4) @(posedge clock);
      $display("Run covered %0d commands over %0d register settings, with a %0d-cycle",
               items_sent, settings_count, HOLD_CYCLES);
      $display("response stall and a stretch without gaps; %0d responses checked.",
               responses_checked);
      if (mismatch_count == 0 && port_reports.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d responses missing.", mismatch_count, port_reports.size());
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin : drain
      logic steady;
      logic hold_done;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && items_sent >= HOLD_START) begin
            // Long hold so the output buffer fills and the request side stalls.
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         steady = (items_sent >= STEADY_FIRST && items_sent < STEADY_LAST);
         rsp_tready <= steady || ($urandom_range(99) >= 33);
      end
   end

   always @(posedge clock) begin : check_rsp
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_type'(rsp_tdata);
         if (port_reports.size() == 0) begin
            flag_mismatch("transaction with nothing awaited", '0, rsp_tdata);
         end else begin
            want = port_reports.pop_front();
            responses_checked++;
            if (got.read_bit !== want.read_bit)
               flag_mismatch("read_bit", want.read_bit, got.read_bit);
            if (got.pending !== want.pending)
               flag_mismatch("pending", want.pending, got.pending);
            if (got.pad_drive !== want.pad_drive)
               flag_mismatch("pad_drive", want.pad_drive, got.pad_drive);
            if (got.pad_output_enable !== want.pad_output_enable)
               flag_mismatch("pad_output_enable", want.pad_output_enable, got.pad_output_enable);
            if (got.irq !== want.irq)
               flag_mismatch("irq", want.irq, got.irq);
         end
      end
   end

endmodule

/* files.f */
hw/rtl/gpe_pkg.sv
hw/rtl/gpe_csr.sv
hw/rtl/gpe_core.sv
hw/rtl/gpe_skid.sv
hw/rtl/gpio_port_with_edge_interrupts.sv
test/tb_top.sv
